[src/polyline_turn_point_filter_unit_defines.svh]
// ---------------------------------------------------------------------------
// polyline turn point filter: assertion macros
// Concurrent check wrappers on clk with arst_n as disable; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef POLYLINE_TURN_POINT_FILTER_UNIT_DEFINES_SVH
`define POLYLINE_TURN_POINT_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PTPF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ptpf check failed");
// expression must never be true
`define PTPF_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("ptpf forbidden condition");
`else
`define PTPF_ASSERT(lbl, prop)
`define PTPF_NEVER(lbl, expr)
`endif

`endif

[src/ptpf_pkg.sv]
// ---------------------------------------------------------------------------
// ptpf_pkg
// Shared widths, codes and beat types of the polyline turn point filter.
// ---------------------------------------------------------------------------
package ptpf_pkg;

	// coordinate and threshold widths
	localparam int CW    = 24;
	localparam int THR_W = 23;
	// multiplier operand width: covers line offsets and threshold squared
	localparam int OP_W  = (2 * CW + 4 > 2 * THR_W + 2) ? 2 * CW + 4 : 2 * THR_W + 2;
	localparam int PW    = 2 * OP_W;

	// input actions
	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_END   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// register indexes
	localparam logic REG_THR  = 1'b0;
	localparam logic REG_MODE = 1'b1;

	typedef struct packed {
		logic [1:0]           action;
		logic signed [CW-1:0] pos_x;
		logic signed [CW-1:0] pos_y;
	} in_beat_t;

	typedef struct packed {
		logic signed [CW-1:0] out_x;
		logic signed [CW-1:0] out_y;
		logic                 last;
	} out_beat_t;

	// multiplier handshake toward the sequencer
	typedef struct packed {
		logic done;
	} mul_stat_t;

endpackage

[src/ptpf_mul.sv]
// ---------------------------------------------------------------------------
// ptpf_mul
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle,
// stops as soon as the remaining multiplier bits are zero.
// ---------------------------------------------------------------------------
module ptpf_mul #(
	parameter int OP_W = ptpf_pkg::OP_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [OP_W-1:0]   op_a,
	input  logic signed [OP_W-1:0]   op_b,
	output ptpf_pkg::mul_stat_t      stat,
	output logic signed [2*OP_W-1:0] prod
);
	import ptpf_pkg::*;

	localparam int P_W = 2 * OP_W;

	logic [P_W-1:0]  mc_q;
	logic [P_W-1:0]  acc_q;
	logic [OP_W-1:0] mp_q;
	logic            neg_q;
	logic            run_q;
	logic            done_q;
	logic signed [P_W-1:0] prod_q;
	logic [OP_W-1:0] mag_a;
	logic [OP_W-1:0] mag_b;

	// operand magnitudes
	assign mag_a = op_a[OP_W-1] ? OP_W'(-op_a) : OP_W'(op_a);
	assign mag_b = op_b[OP_W-1] ? OP_W'(-op_b) : OP_W'(op_b);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && mp_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// shift-add datapath
	always_ff @(posedge clk) begin
		if (start) begin
			mc_q  <= P_W'(mag_a);
			mp_q  <= mag_b;
			acc_q <= '0;
			neg_q <= op_a[OP_W-1] ^ op_b[OP_W-1];
		end else if (run_q) begin
			if (mp_q == '0) begin
				prod_q <= neg_q ? -$signed(acc_q) : $signed(acc_q);
			end else begin
				if (mp_q[0]) begin
					acc_q <= acc_q + mc_q;
				end
				mc_q <= mc_q << 1;
				mp_q <= mp_q >> 1;
			end
		end
	end

	assign stat.done = done_q;
	assign prod      = prod_q;

endmodule

[src/polyline_turn_point_filter_unit.sv]
// ---------------------------------------------------------------------------
// polyline_turn_point_filter_unit
// Track point filter that keeps only the corner points of a polyline.
// ---------------------------------------------------------------------------
// Takes one beat at a time. End, clear, a first point and a point equal to
// the previous one are handled in the cycle they are accepted. A second
// point runs two products, a later point eleven, plus two more when it
// makes a corner, all on one bit-serial shift-add multiplier that steps
// through the significant bits of each product's second operand. Results
// go into a four-entry output queue; a new beat is taken while up to two
// results still wait there.
// ---------------------------------------------------------------------------
`include "polyline_turn_point_filter_unit_defines.svh"

module polyline_turn_point_filter_unit #(
	parameter int OP_W = ptpf_pkg::OP_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic                        wr_index,
	input  logic [ptpf_pkg::THR_W-1:0]  wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ptpf_pkg::in_beat_t          in_beat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ptpf_pkg::out_beat_t         out_beat
);
	import ptpf_pkg::*;

	localparam int P_W = 2 * OP_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;

	localparam logic [3:0] OP_AX  = 4'd0;
	localparam logic [3:0] OP_BY  = 4'd1;
	localparam logic [3:0] OP_VV  = 4'd2;
	localparam logic [3:0] OP_TT  = 4'd3;
	localparam logic [3:0] OP_AA  = 4'd4;
	localparam logic [3:0] OP_BB  = 4'd5;
	localparam logic [3:0] OP_RHS = 4'd6;
	localparam logic [3:0] OP_RT0 = 4'd7;
	localparam logic [3:0] OP_RT1 = 4'd8;
	localparam logic [3:0] OP_RP0 = 4'd9;
	localparam logic [3:0] OP_RP1 = 4'd10;
	localparam logic [3:0] OP_L0  = 4'd11;
	localparam logic [3:0] OP_L1  = 4'd12;

	logic [1:0]  state_q;
	logic [3:0]  op_q;
	logic [THR_W-1:0] thr_q;
	logic        mode_q;
	logic [1:0]  cnt_q;
	logic signed [CW-1:0] px_q, py_q, tx_q, ty_q, ix_q, iy_q;
	logic signed [CW:0]   a_q, b_q;
	logic signed [OP_W-1:0] c_q, v_q, tt_q, nrm_q;
	logic signed [P_W-1:0]  t0_q, vv_q;
	logic        off_q, tneg_q, tzero_q;

	logic        mul_start;
	mul_stat_t   mul_stat;
	logic signed [OP_W-1:0] opa, opb;
	logic signed [P_W-1:0]  mul_p, sum_w;
	logic signed [OP_W-1:0] spx, spy, stx, sty, six, siy, na, nb;
	logic        in_fire, mul_done, rev, corner;

	out_beat_t   fifo_q [4];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  fcnt_q;
	logic [1:0]  push_n;
	out_beat_t   push_d0, push_d1;
	logic        pop;

	assign in_ready  = (state_q == ST_IDLE) && (fcnt_q <= 3'd2);
	assign in_fire   = in_valid && in_ready;
	assign mul_done  = mul_stat.done;
	assign mul_start = (state_q == ST_ISSUE);

	// sign-extended coordinates and new line coefficients
	assign spx = OP_W'(px_q);
	assign spy = OP_W'(py_q);
	assign stx = OP_W'(tx_q);
	assign sty = OP_W'(ty_q);
	assign six = OP_W'(ix_q);
	assign siy = OP_W'(iy_q);
	assign na  = siy - spy;
	assign nb  = spx - six;
	assign sum_w = t0_q + mul_p;

	// operand select per micro-op
	always_comb begin
		opa = '0;
		opb = '0;
		unique case (op_q)
			OP_AX: begin opa = OP_W'(a_q); opb = six; end
			OP_BY: begin opa = OP_W'(b_q); opb = siy; end
			OP_VV: begin opa = v_q; opb = v_q; end
			OP_TT: begin opa = OP_W'({1'b0, thr_q}); opb = OP_W'({1'b0, thr_q}); end
			OP_AA: begin opa = OP_W'(a_q); opb = OP_W'(a_q); end
			OP_BB: begin opa = OP_W'(b_q); opb = OP_W'(b_q); end
			OP_RHS: begin opa = tt_q; opb = nrm_q; end
			OP_RT0: begin opa = spx - stx; opb = stx - spx; end
			OP_RT1: begin opa = spy - sty; opb = sty - spy; end
			OP_RP0: begin opa = spx - stx; opb = six - spx; end
			OP_RP1: begin opa = spy - sty; opb = siy - spy; end
			OP_L0: begin opa = na; opb = spx; end
			OP_L1: begin opa = nb; opb = spy; end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	ptpf_mul #(.OP_W(OP_W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (opa),
		.op_b   (opb),
		.stat   (mul_stat),
		.prod   (mul_p)
	);

	// reversal and corner decision at the last perpendicular product
	assign rev    = (tneg_q == sum_w[P_W-1]) && !tzero_q && (sum_w != '0);
	assign corner = (state_q == ST_WAIT) && mul_done && (op_q == OP_RP1) && (off_q || rev);

	// result beats produced this cycle
	always_comb begin
		push_n  = 2'd0;
		push_d0 = '{out_x: px_q, out_y: py_q, last: 1'b1};
		push_d1 = '{out_x: px_q, out_y: py_q, last: 1'b1};
		if (in_fire && in_beat.action == ACT_END && cnt_q != 2'd0) begin
			push_n = 2'd1;
		end else if (in_fire && in_beat.action == ACT_PUSH && cnt_q == 2'd0) begin
			push_n  = 2'd1;
			push_d0 = '{out_x: in_beat.pos_x, out_y: in_beat.pos_y, last: 1'b1};
		end else if (corner) begin
			if (mode_q) begin
				push_n  = 2'd2;
				push_d0 = '{out_x: tx_q, out_y: ty_q, last: 1'b0};
			end else begin
				push_n = 2'd1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_W'(2);
			mode_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_THR:  thr_q  <= wr_data;
				REG_MODE: mode_q <= wr_data[0];
				default:  thr_q  <= thr_q;
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 2'd0;
			op_q    <= OP_AX;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						priority if (in_beat.action == ACT_END || in_beat.action == ACT_CLEAR) begin
							cnt_q <= 2'd0;
						end else if (in_beat.action == ACT_PUSH) begin
							if (cnt_q == 2'd0) begin
								cnt_q <= 2'd1;
							end else if (in_beat.pos_x != px_q || in_beat.pos_y != py_q) begin
								op_q    <= (cnt_q == 2'd1) ? OP_L0 : OP_AX;
								state_q <= ST_ISSUE;
							end
						end else begin
							cnt_q <= cnt_q;
						end
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (mul_done) begin
						state_q <= ST_ISSUE;
						unique case (op_q)
							OP_RP1: begin
								if (off_q || rev) begin
									op_q <= OP_L0;
								end else begin
									state_q <= ST_IDLE;
								end
							end
							OP_L1: begin
								cnt_q   <= 2'd2;
								state_q <= ST_IDLE;
							end
							default: op_q <= op_q + 4'd1;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// point history, line and intermediate products
	always_ff @(posedge clk) begin
		if (in_fire && in_beat.action == ACT_PUSH) begin
			if (cnt_q == 2'd0) begin
				tx_q <= px_q;
				ty_q <= py_q;
				px_q <= in_beat.pos_x;
				py_q <= in_beat.pos_y;
			end
			ix_q <= in_beat.pos_x;
			iy_q <= in_beat.pos_y;
		end
		if (state_q == ST_WAIT && mul_done) begin
			unique case (op_q)
				OP_AX:  t0_q  <= mul_p;
				OP_BY:  v_q   <= OP_W'(sum_w + P_W'(c_q));
				OP_VV:  vv_q  <= mul_p;
				OP_TT:  tt_q  <= OP_W'(mul_p);
				OP_AA:  nrm_q <= OP_W'(mul_p);
				OP_BB:  nrm_q <= OP_W'(mul_p + P_W'(nrm_q));
				OP_RHS: off_q <= vv_q > mul_p;
				OP_RT0: t0_q  <= mul_p;
				OP_RT1: begin
					tneg_q  <= sum_w[P_W-1];
					tzero_q <= (sum_w == '0);
				end
				OP_RP0: t0_q  <= mul_p;
				OP_RP1: begin
					if (!(off_q || rev)) begin
						tx_q <= px_q;
						ty_q <= py_q;
						px_q <= ix_q;
						py_q <= iy_q;
					end
				end
				OP_L0:  t0_q  <= mul_p;
				OP_L1: begin
					a_q  <= (CW+1)'(na);
					b_q  <= (CW+1)'(nb);
					c_q  <= OP_W'(-sum_w);
					tx_q <= px_q;
					ty_q <= py_q;
					px_q <= ix_q;
					py_q <= iy_q;
				end
				default: t0_q <= t0_q;
			endcase
		end
	end

	// output queue
	assign pop       = out_valid && out_ready;
	assign out_valid = (fcnt_q != 3'd0);
	assign out_beat  = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 2'd0;
			rp_q   <= 2'd0;
			fcnt_q <= 3'd0;
		end else begin
			wp_q   <= wp_q + push_n;
			rp_q   <= rp_q + {1'b0, pop};
			fcnt_q <= fcnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wp_q] <= push_d0;
		end
		if (push_n == 2'd2) begin
			fifo_q[wp_q + 2'd1] <= push_d1;
		end
	end

	// checks
	`PTPF_NEVER(a_fifo_overflow, fcnt_q > 3'd4)
	`PTPF_ASSERT(a_mul_done_in_wait, mul_done |-> state_q == ST_WAIT)
	`PTPF_ASSERT(a_full_blocks_input, fcnt_q > 3'd2 |-> !in_ready)
	`PTPF_ASSERT(a_push_starts_seq, (in_fire && in_beat.action == ACT_PUSH && cnt_q == 2'd2 && (in_beat.pos_x != px_q || in_beat.pos_y != py_q)) |=> (state_q == ST_ISSUE && op_q == OP_AX))

endmodule

[tb/ptpf_checker.sv]
// ---------------------------------------------------------------------------
// ptpf_checker
// Watches the register port and both beat channels of the polyline turn
// point filter. It predicts the kept points from its own copy of the filter
// state and compares each output beat with the oldest predicted point.
// ---------------------------------------------------------------------------
module ptpf_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic                       wr_index,
	input  logic [ptpf_pkg::THR_W-1:0] wr_data,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  ptpf_pkg::in_beat_t         in_beat,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  ptpf_pkg::out_beat_t        out_beat,
	output int                         fail_count,
	output int                         pending,
	output int                         corner_count,
	output int                         kept_count
);
	import ptpf_pkg::*;

	typedef logic signed [127:0] wide_t;

	// shadow registers and filter state
	logic [THR_W-1:0]     thr;
	logic                 mode2;
	logic [1:0]           npts;
	logic signed [CW-1:0] rx, ry, tx, ty;
	logic signed [CW:0]   la, lb;
	wide_t                lc;

	ptpf_pkg::out_beat_t kept_q[$];

	// restart the reference line through two points
	task automatic restart_line(input logic signed [CW-1:0] x0, y0, x1, y1);
		wide_t wx0, wy0, wa, wb;
		wx0 = x0;
		wy0 = y0;
		la = (CW+1)'(y1) - (CW+1)'(y0);
		lb = (CW+1)'(x0) - (CW+1)'(x1);
		wa = la;
		wb = lb;
		lc = -(wa * wx0 + wb * wy0);
	endtask

	function automatic logic off_line(input logic signed [CW-1:0] x, y);
		wide_t wx, wy, wa, wb, v, t, nrm;
		wx = x;
		wy = y;
		wa = la;
		wb = lb;
		t = {105'd0, thr};
		v = wa * wx + wb * wy + lc;
		nrm = wa * wa + wb * wb;
		return (v * v) > (t * t * nrm);
	endfunction

	// signed side of the perpendicular through the previous point
	function automatic wide_t side_of(input logic signed [CW-1:0] x, y);
		wide_t pa, pb, dx, dy, sx, sy;
		pa = ry; pb = ty; pa = pa - pb;
		sx = tx; pb = rx; pb = sx - pb;
		sx = x; sy = rx; dx = sx - sy;
		sx = y; sy = ry; dy = sx - sy;
		return (-pb) * dx + pa * dy;
	endfunction

	task automatic keep_point(input logic signed [CW-1:0] x, y);
		ptpf_pkg::out_beat_t b;
		b.out_x = x;
		b.out_y = y;
		b.last = 1'b0;
		kept_q.push_back(b);
	endtask

	task automatic clear_track();
		npts = 0;
		rx = 0; ry = 0; tx = 0; ty = 0;
		la = 0; lb = 0; lc = 0;
	endtask

	// work out the kept points caused by one input beat
	task automatic predict_beat(input ptpf_pkg::in_beat_t b);
		int n0;
		logic corner;
		wide_t s;
		n0 = kept_q.size();
		if (b.action == ACT_END) begin
			if (npts != 0) keep_point(rx, ry);
			clear_track();
		end else if (b.action == ACT_CLEAR) begin
			clear_track();
		end else if (b.action == ACT_PUSH) begin
			if (npts == 0) begin
				keep_point(b.pos_x, b.pos_y);
			end else if (b.pos_x == rx && b.pos_y == ry) begin
				return;
			end else if (npts == 1) begin
				restart_line(rx, ry, b.pos_x, b.pos_y);
			end else begin
				s = side_of(tx, ty) * side_of(b.pos_x, b.pos_y);
				corner = off_line(b.pos_x, b.pos_y) || (s > 0);
				if (corner) begin
					corner_count++;
					if (mode2) keep_point(tx, ty);
					keep_point(rx, ry);
					restart_line(rx, ry, b.pos_x, b.pos_y);
				end
			end
			tx = rx;
			ty = ry;
			rx = b.pos_x;
			ry = b.pos_y;
			if (npts < 2) npts++;
		end
		if (kept_q.size() > n0) kept_q[$].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr = 2;
			mode2 = 0;
			clear_track();
			kept_q.delete();
			fail_count = 0;
			corner_count = 0;
			kept_count = 0;
			pending = 0;
		end else begin
			// register writes
			if (wr_en) begin
				if (wr_index == REG_THR) thr = wr_data;
				else mode2 = wr_data[0];
			end
			// input beat
			if (in_valid && in_ready) predict_beat(in_beat);
			// output beat
			if (out_valid && out_ready) begin
				kept_count++;
				if (kept_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected beat x=%0d y=%0d last=%0b",
							out_beat.out_x, out_beat.out_y, out_beat.last);
				end else begin
					if (out_beat !== kept_q[0]) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
								kept_q[0].out_x, kept_q[0].out_y, kept_q[0].last,
								out_beat.out_x, out_beat.out_y, out_beat.last);
					end
					void'(kept_q.pop_front());
				end
			end
			pending = kept_q.size();
		end
	end
endmodule

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the polyline turn point filter: directed tracks,
// then random tracks over several threshold and mode settings and three
// flow-control patterns, checked by ptpf_checker.
// ---------------------------------------------------------------------------
module tb;
	import ptpf_pkg::*;

	localparam logic [1:0] ACT_NOOP = 2'd3;
	localparam int WATCH_LIMIT = 40000;
	localparam int DRAIN_CYCLES = 1000;

	logic clk = 0;
	logic arst_n = 0;
	logic wr_en = 0;
	logic wr_index = 0;
	logic [THR_W-1:0] wr_data = 0;
	logic in_valid = 0;
	logic in_ready;
	in_beat_t in_beat = '0;
	logic out_valid;
	logic out_ready = 0;
	out_beat_t out_beat;

	int fail_count, pending, corner_count, kept_count;
	int in_idle, out_idle;
	int sent, quiet;
	logic signed [CW-1:0] px, py;

	always #5 clk = ~clk;

	polyline_turn_point_filter_unit DUT (
		.clk, .arst_n, .wr_en, .wr_index, .wr_data,
		.in_valid, .in_ready, .in_beat,
		.out_valid, .out_ready, .out_beat
	);

	ptpf_checker u_chk (
		.clk, .arst_n, .wr_en, .wr_index, .wr_data,
		.in_valid, .in_ready, .in_beat,
		.out_valid, .out_ready, .out_beat,
		.fail_count, .pending, .corner_count, .kept_count
	);

	// receiver stalls
	always @(posedge clk) out_ready <= ($urandom_range(99) >= out_idle);

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || wr_en) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCH_LIMIT) begin
			$display("timeout with %0d points outstanding", pending);
			$display("Test completed with failures");
			$finish;
		end
	end

	// one input beat, with a random gap in front of it
	task automatic send_beat(input logic [1:0] act, input logic signed [CW-1:0] x, y);
		if ($urandom_range(99) < in_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < in_idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_beat.action <= act;
		in_beat.pos_x <= x;
		in_beat.pos_y <= y;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		if (act != ACT_NOOP) sent++;
	endtask

	task automatic push(input logic signed [CW-1:0] x, y);
		send_beat(ACT_PUSH, x, y);
	endtask

	// wait until the block has drained, then write a register
	task automatic write_reg(input logic idx, input logic [THR_W-1:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// random track: mostly small steps, some repeats and jumps
	task automatic random_track();
		int len, k, r, step;
		len = $urandom_range(1, 24);
		step = 1 << $urandom_range(0, 10);
		if ($urandom_range(3) == 0) begin
			px = CW'($urandom); py = CW'($urandom);
		end else begin
			px = $signed(11'($urandom)); py = $signed(11'($urandom));
		end
		for (k = 0; k < len; k++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				// repeat previous point
			end else if (r < 12) begin
				px = CW'($urandom); py = CW'($urandom);
			end else begin
				px = CW'(px + $signed($urandom_range(0, 2 * step)) - step);
				py = CW'(py + $signed($urandom_range(0, 2 * step)) - step);
			end
			push(px, py);
		end
		r = $urandom_range(99);
		if (r < 75) send_beat(ACT_END, CW'($urandom), CW'($urandom));
		else if (r < 90) send_beat(ACT_CLEAR, CW'($urandom), CW'($urandom));
		else if (r < 95) send_beat(ACT_NOOP, CW'($urandom), CW'($urandom));
	endtask

	initial begin
		int ph;
		logic [THR_W-1:0] thr_val;
		in_idle = 0;
		out_idle = 0;
		sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: end and clear on empty, single point, reset threshold
		send_beat(ACT_END, 0, 0);
		send_beat(ACT_CLEAR, 24'h7fffff, 24'h800000);
		send_beat(ACT_NOOP, 24'h800000, 24'h7fffff);
		push(24'sh7fffff, 24'sh800000);
		send_beat(ACT_END, 0, 0);
		// coincident point, straight line, offset corner, reversal
		push(0, 0); push(0, 0); push(10, 0); push(10, 0);
		push(20, 1); push(30, 9); push(40, 9); push(35, 9);
		send_beat(ACT_END, 0, 0);
		// extreme coordinates
		push(24'sh800000, 24'sh800000); push(24'sh7fffff, 24'sh7fffff);
		push(24'sh800000, 24'sh7fffff); push(24'sh7fffff, 24'sh800000);
		send_beat(ACT_CLEAR, 0, 0);
		// second mode and threshold extremes
		write_reg(REG_MODE, 1);
		write_reg(REG_THR, 0);
		push(0, 0); push(5, 0); push(10, 1); push(15, 1); push(10, 1);
		send_beat(ACT_END, 0, 0);
		write_reg(REG_THR, {THR_W{1'b1}});
		push(24'sh800000, 0); push(0, 0); push(24'sh7fffff, 24'sh7fffff);
		push(0, 24'sh800000);
		send_beat(ACT_END, 0, 0);

		// random phases: settings and flow-control patterns
		for (ph = 0; ph < 6; ph++) begin
			case (ph % 4)
				0: thr_val = 0;
				1: thr_val = THR_W'($urandom_range(1, 64));
				2: thr_val = {THR_W{1'b1}};
				default: thr_val = THR_W'($urandom);
			endcase
			write_reg(REG_THR, thr_val);
			write_reg(REG_MODE, THR_W'(ph[0]));
			case (ph / 2)
				0: begin in_idle = 30; out_idle = 78; end
				1: begin in_idle = 78; out_idle = 30; end
				default: begin in_idle = 0; out_idle = 0; end
			endcase
			while (sent < 40 + (ph + 1) * 235) random_track();
		end

		// drain
		in_valid <= 1'b0;
		out_idle = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d input beats, %0d kept points, %0d corners over six settings",
			sent, kept_count, corner_count);
		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d points outstanding", fail_count, pending);
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

[sim.f]
+incdir+src
src/ptpf_pkg.sv
src/ptpf_mul.sv
src/polyline_turn_point_filter_unit.sv
tb/ptpf_checker.sv
tb/tb.sv
